// ===== rtl/sra_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the shelf allocator.
package sra_pkg;

  // Default configuration of the atlas pages
  localparam int ATLAS_WIDTH_DEF = 3 * 1024;
  localparam int ATLAS_HEIGHT_DEF = 1024;
  localparam int MAX_ATLASES_DEF = 4;
  localparam int MAX_ROWS_DEF = 256;

  // Field widths of the item ports
  localparam int REQ_WIDTH_W = 12;
  localparam int REQ_HEIGHT_W = 11;
  localparam int STATUS_W = 2;
  localparam int ATLAS_IDX_W = 2;
  localparam int ROW_IDX_W = 8;
  localparam int X_W = 12;
  localparam int Y_W = 10;
  localparam int RHEIGHT_W = 11;

  // Internal counter widths
  localparam int ROW_CNT_W = 9;
  localparam int ATLAS_CNT_W = 3;
  localparam int TOP_W = 11;
  localparam int HCALC_W = 12;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED   = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_NO_SLOT  = 2'd2
  } status_t;

  // How the current item ends
  typedef enum logic [1:0] {
    OUT_HIT,
    OUT_NEW,
    OUT_SIZE,
    OUT_FULL
  } outcome_t;

  typedef struct packed {
    logic     load;
    logic     scan_start;
    logic     scan_en;
    logic     pick;
    logic     commit;
    outcome_t outcome;
  } dp_cmd_t;

  typedef struct packed {
    logic oversize;
    logic hit;
    logic scan_done;
    logic no_room;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/sra_ctrl.sv =====
// Sequencing state machine of the shelf allocator.
module sra_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sra_pkg::dp_sts_t sts,
  output sra_pkg::dp_cmd_t cmd
);
  import sra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_PICK,
    S_COMMIT
  } state_t;

  state_t   state_r, state_nxt;
  outcome_t outcome_r, outcome_nxt;

  always_comb begin
    state_nxt = state_r;
    outcome_nxt = outcome_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.oversize) begin
          outcome_nxt = OUT_SIZE;
          state_nxt = S_COMMIT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          outcome_nxt = OUT_HIT;
          state_nxt = S_COMMIT;
        end else if (sts.scan_done) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        outcome_nxt = sts.no_room ? OUT_FULL : OUT_NEW;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      outcome_r <= OUT_HIT;
    end else begin
      state_r <= state_nxt;
      outcome_r <= outcome_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd.load = in_valid && (state_r == S_IDLE);
    cmd.scan_start = (state_r == S_CHECK);
    cmd.scan_en = (state_r == S_SCAN);
    cmd.pick = (state_r == S_PICK);
    cmd.commit = (state_r == S_COMMIT) && sts.out_free;
    cmd.outcome = outcome_r;
  end

endmodule

// ===== rtl/sra_datapath.sv =====
// Row store, first-fit scan, new-row selection and result register of the shelf allocator.
module sra_datapath #(
  parameter int ATLAS_WIDTH = sra_pkg::ATLAS_WIDTH_DEF,
  parameter int ATLAS_HEIGHT = sra_pkg::ATLAS_HEIGHT_DEF,
  parameter int MAX_ATLASES = sra_pkg::MAX_ATLASES_DEF,
  parameter int MAX_ROWS = sra_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [sra_pkg::REQ_WIDTH_W-1:0]  in_req_width,
  input  logic [sra_pkg::REQ_HEIGHT_W-1:0] in_req_height,
  input  sra_pkg::dp_cmd_t                 cmd,
  output sra_pkg::dp_sts_t                 sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sra_pkg::STATUS_W-1:0]     out_status,
  output logic [sra_pkg::ATLAS_IDX_W-1:0]  out_atlas_index,
  output logic [sra_pkg::ROW_IDX_W-1:0]    out_row_index,
  output logic [sra_pkg::X_W-1:0]          out_x_offset,
  output logic [sra_pkg::Y_W-1:0]          out_y_offset,
  output logic [sra_pkg::RHEIGHT_W-1:0]    out_rounded_height,
  output logic                             out_new_atlas
);
  import sra_pkg::*;

  localparam int AIDX_W = (MAX_ATLASES > 1) ? $clog2(MAX_ATLASES) : 1;
  localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SLOTS = MAX_ATLASES * MAX_ROWS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [HCALC_W:0] AW_LIM = (HCALC_W + 1)'(ATLAS_WIDTH);
  localparam logic [HCALC_W:0] AH_LIM = (HCALC_W + 1)'(ATLAS_HEIGHT);
  localparam logic [ROW_CNT_W-1:0] ROW_LIM = ROW_CNT_W'(MAX_ROWS);
  localparam logic [ATLAS_CNT_W-1:0] ATLAS_LIM = ATLAS_CNT_W'(MAX_ATLASES);
  localparam logic [SLOT_W-1:0] ROW_STRIDE = SLOT_W'(MAX_ROWS);

  typedef struct packed {
    logic [RHEIGHT_W-1:0] height;
    logic [X_W-1:0]       fill;
    logic [Y_W-1:0]       top;
  } row_entry_t;

  // Row store, one entry per atlas row slot
  row_entry_t mem [SLOTS];
  row_entry_t rd_r;

  logic [REQ_WIDTH_W-1:0] w_r;
  logic [HCALC_W-1:0]     h_r;
  logic [HCALC_W-1:0]     h_round;

  // Scan iterator and compare stage
  logic [ATLAS_CNT_W-1:0] a_r;
  logic [ROW_CNT_W-1:0]   r_r;
  logic                   cv_r;
  logic [AIDX_W-1:0]      ca_r;
  logic [RIDX_W-1:0]      cr_r;
  logic [AIDX_W-1:0]      a_idx;
  logic                   iter_in;
  logic                   iter_row;
  logic [SLOT_W-1:0]      rd_addr;
  logic                   fit;
  logic                   hit;

  // Per-atlas bookkeeping
  logic [ROW_CNT_W-1:0]   rows_r [MAX_ATLASES];
  logic [TOP_W-1:0]       top_r [MAX_ATLASES];
  logic [ATLAS_CNT_W-1:0] atlas_cnt_r;

  logic                   pick_have;
  logic [AIDX_W-1:0]      pick_idx;

  // Chosen row
  logic [AIDX_W-1:0]      sel_atlas_r;
  logic [RIDX_W-1:0]      sel_row_r;
  logic [X_W-1:0]         sel_fill_r;
  logic [Y_W-1:0]         sel_top_r;
  logic                   fresh_r;

  logic                   commit_place;
  logic                   commit_new;
  logic [SLOT_W-1:0]      wr_addr;
  row_entry_t             wr_entry;

  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [ATLAS_IDX_W-1:0] out_atlas_r;
  logic [ROW_IDX_W-1:0]   out_row_r;
  logic [X_W-1:0]         out_x_r;
  logic [Y_W-1:0]         out_y_r;
  logic [RHEIGHT_W-1:0]   out_rh_r;
  logic                   out_new_r;

  assign h_round = (HCALC_W'(in_req_height) + HCALC_W'(3)) & ~HCALC_W'(3);

  assign a_idx = a_r[AIDX_W-1:0];
  assign iter_in = (a_r < atlas_cnt_r);
  assign iter_row = iter_in && (r_r < rows_r[a_idx]);
  assign rd_addr = SLOT_W'(a_idx) * ROW_STRIDE + SLOT_W'(r_r[RIDX_W-1:0]);

  // A row fits when its leftover width covers the request
  assign fit = ((HCALC_W + 1)'(rd_r.fill) > AW_LIM) ||
               ((HCALC_W + 1)'(rd_r.fill) + (HCALC_W + 1)'(w_r) <= AW_LIM);
  assign hit = cv_r && (HCALC_W'(rd_r.height) == h_r) && fit;

  // First open atlas with a free row slot and vertical room
  always_comb begin
    pick_have = 1'b0;
    pick_idx = '0;
    for (int i = 0; i < MAX_ATLASES; i++) begin
      if (!pick_have && (ATLAS_CNT_W'(i) < atlas_cnt_r) && (rows_r[i] < ROW_LIM) &&
          ((HCALC_W + 1)'(top_r[i]) < AH_LIM) &&
          ((HCALC_W + 1)'(top_r[i]) + (HCALC_W + 1)'(h_r) <= AH_LIM)) begin
        pick_have = 1'b1;
        pick_idx = AIDX_W'(i);
      end
    end
  end

  always_comb begin
    sts.oversize = ((HCALC_W + 1)'(w_r) > AW_LIM) || ((HCALC_W + 1)'(h_r) > AH_LIM);
    sts.hit = hit;
    sts.scan_done = !iter_in && !cv_r;
    sts.no_room = !pick_have && (atlas_cnt_r >= ATLAS_LIM);
    sts.out_free = !out_valid_r || out_ready;
  end

  assign commit_place = cmd.commit && ((cmd.outcome == OUT_HIT) || (cmd.outcome == OUT_NEW));
  assign commit_new = cmd.commit && (cmd.outcome == OUT_NEW);
  assign wr_addr = SLOT_W'(sel_atlas_r) * ROW_STRIDE + SLOT_W'(sel_row_r);

  always_comb begin
    wr_entry.height = h_r[RHEIGHT_W-1:0];
    wr_entry.fill = sel_fill_r + w_r;
    wr_entry.top = sel_top_r;
  end

  // Row store port: one write at commit, one registered read per cycle
  always_ff @(posedge clk) begin
    if (commit_place) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_r <= mem[rd_addr];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r <= in_req_width;
      h_r <= h_round;
    end
    if (cmd.scan_en) begin
      ca_r <= a_idx;
      cr_r <= r_r[RIDX_W-1:0];
    end
    if (cmd.scan_en && hit) begin
      sel_atlas_r <= ca_r;
      sel_row_r <= cr_r;
      sel_fill_r <= rd_r.fill;
      sel_top_r <= rd_r.top;
      fresh_r <= 1'b0;
    end else if (cmd.pick) begin
      sel_fill_r <= '0;
      if (pick_have) begin
        sel_atlas_r <= pick_idx;
        sel_row_r <= rows_r[pick_idx][RIDX_W-1:0];
        sel_top_r <= top_r[pick_idx][Y_W-1:0];
        fresh_r <= 1'b0;
      end else begin
        sel_atlas_r <= atlas_cnt_r[AIDX_W-1:0];
        sel_row_r <= '0;
        sel_top_r <= '0;
        fresh_r <= 1'b1;
      end
    end
    if (cmd.commit) begin
      if (commit_place) begin
        out_status_r <= ST_PLACED;
        out_atlas_r <= ATLAS_IDX_W'(sel_atlas_r);
        out_row_r <= ROW_IDX_W'(sel_row_r);
        out_x_r <= sel_fill_r;
        out_y_r <= sel_top_r;
        out_rh_r <= h_r[RHEIGHT_W-1:0];
        out_new_r <= fresh_r;
      end else begin
        out_status_r <= (cmd.outcome == OUT_SIZE) ? ST_OVERSIZE : ST_NO_SLOT;
        out_atlas_r <= '0;
        out_row_r <= '0;
        out_x_r <= '0;
        out_y_r <= '0;
        out_rh_r <= '0;
        out_new_r <= 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      r_r <= '0;
      cv_r <= 1'b0;
      atlas_cnt_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_ATLASES; i++) begin
        rows_r[i] <= '0;
        top_r[i] <= '0;
      end
    end else begin
      if (cmd.scan_start) begin
        a_r <= '0;
        r_r <= '0;
        cv_r <= 1'b0;
      end else if (cmd.scan_en && iter_row) begin
        r_r <= r_r + 1'b1;
        cv_r <= 1'b1;
      end else if (cmd.scan_en && iter_in) begin
        a_r <= a_r + 1'b1;
        r_r <= '0;
        cv_r <= 1'b0;
      end else begin
        cv_r <= 1'b0;
      end
      if (commit_new) begin
        rows_r[sel_atlas_r] <= rows_r[sel_atlas_r] + 1'b1;
        top_r[sel_atlas_r] <= TOP_W'(sel_top_r) + h_r[TOP_W-1:0];
        if (fresh_r) begin
          atlas_cnt_r <= atlas_cnt_r + 1'b1;
        end
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_atlas_index = out_atlas_r;
  assign out_row_index = out_row_r;
  assign out_x_offset = out_x_r;
  assign out_y_offset = out_y_r;
  assign out_rounded_height = out_rh_r;
  assign out_new_atlas = out_new_r;

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("result committed over an untaken item");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_PLACED)) |->
      (out_atlas_r == '0) && (out_row_r == '0) && (out_x_r == '0) &&
      (out_y_r == '0) && (out_rh_r == '0) && !out_new_r)
    else $error("error item carries placement fields");

  a_atlas_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    atlas_cnt_r <= ATLAS_LIM)
    else $error("atlas count beyond page limit");

  a_new_row_counted: assert property (@(posedge clk) disable iff (!rst_n)
    commit_new |=> rows_r[$past(sel_atlas_r)] == ($past(rows_r[sel_atlas_r]) + 1'b1))
    else $error("new row not counted in its atlas");

endmodule

// ===== rtl/shelf_rect_allocator.sv =====
// Top level of the shelf rectangle allocator: controller plus row-store datapath.
// Walk: the first-fit walk reads the stored rows of each open atlas in turn, one row-store
//   read per cycle, and steps across the open atlases one after another.
// Flow: one item at a time; the next item is accepted the cycle after the result is loaded
//   into the output register, even while that result still waits to be taken.
// Reset: synchronous active-low; clears row and atlas counts, no clearing pass of the row store.
module shelf_rect_allocator #(
  parameter int ATLAS_WIDTH = sra_pkg::ATLAS_WIDTH_DEF,
  parameter int ATLAS_HEIGHT = sra_pkg::ATLAS_HEIGHT_DEF,
  parameter int MAX_ATLASES = sra_pkg::MAX_ATLASES_DEF,
  parameter int MAX_ROWS = sra_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sra_pkg::REQ_WIDTH_W-1:0]  in_req_width,
  input  logic [sra_pkg::REQ_HEIGHT_W-1:0] in_req_height,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sra_pkg::STATUS_W-1:0]     out_status,
  output logic [sra_pkg::ATLAS_IDX_W-1:0]  out_atlas_index,
  output logic [sra_pkg::ROW_IDX_W-1:0]    out_row_index,
  output logic [sra_pkg::X_W-1:0]          out_x_offset,
  output logic [sra_pkg::Y_W-1:0]          out_y_offset,
  output logic [sra_pkg::RHEIGHT_W-1:0]    out_rounded_height,
  output logic                             out_new_atlas
);
  import sra_pkg::*;

  // Commands from the sequencer, status back from the datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: idle -> size check -> first-fit walk -> new-row pick -> commit.
  // An oversize item skips straight to commit; a hit in the walk skips the pick.
  sra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: holds the item, walks the row store one slot per cycle, picks the
  // atlas for a new shelf, updates the store and loads the output register.
  sra_datapath #(
    .ATLAS_WIDTH  (ATLAS_WIDTH),
    .ATLAS_HEIGHT (ATLAS_HEIGHT),
    .MAX_ATLASES  (MAX_ATLASES),
    .MAX_ROWS     (MAX_ROWS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_req_width       (in_req_width),
    .in_req_height      (in_req_height),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_atlas_index    (out_atlas_index),
    .out_row_index      (out_row_index),
    .out_x_offset       (out_x_offset),
    .out_y_offset       (out_y_offset),
    .out_rounded_height (out_rounded_height),
    .out_new_atlas      (out_new_atlas)
  );

endmodule

// ===== tb/sv/shelf_rect_allocator_tb.sv =====
// Self-checking testbench for the shelf rectangle allocator with a built-in placement predictor.
`timescale 1ns / 1ps

module shelf_rect_allocator_tb;
  import sra_pkg::*;

  localparam int ATLAS_W = ATLAS_WIDTH_DEF;
  localparam int ATLAS_H = ATLAS_HEIGHT_DEF;
  localparam int ATLAS_MAX = MAX_ATLASES_DEF;
  localparam int ROWS_MAX = MAX_ROWS_DEF;
  localparam int SLOTS = ATLAS_MAX * ROWS_MAX;
  // Longest walk: every row of every atlas, plus fixed pipeline overhead
  localparam int TAIL_CYCLES = 1100;
  // Hard limit on the run length, set well above the slowest legal run
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    status_t                status;
    logic [ATLAS_IDX_W-1:0] atlas;
    logic [ROW_IDX_W-1:0]   row;
    logic [X_W-1:0]         x;
    logic [Y_W-1:0]         y;
    logic [RHEIGHT_W-1:0]   rh;
    logic                   fresh;
  } placement_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [REQ_WIDTH_W-1:0] in_req_width = '0;
  logic [REQ_HEIGHT_W-1:0] in_req_height = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    out_status;
  logic [ATLAS_IDX_W-1:0] out_atlas_index;
  logic [ROW_IDX_W-1:0]   out_row_index;
  logic [X_W-1:0]         out_x_offset;
  logic [Y_W-1:0]         out_y_offset;
  logic [RHEIGHT_W-1:0]   out_rounded_height;
  logic                   out_new_atlas;

  // Predictor state: per-row height, fill and top, rows per atlas, atlases open
  int shelf_height[SLOTS];
  int shelf_fill[SLOTS];
  int shelf_top_px[SLOTS];
  int shelf_count[ATLAS_MAX];
  int atlas_open;

  placement_t pending_placements[$];
  int         mismatch_count = 0;
  int         out_stall = 0;
  int         cycle_count = 0;
  bit         idle_on = 1'b1;

  shelf_rect_allocator u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_width       (in_req_width),
    .in_req_height      (in_req_height),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_atlas_index    (out_atlas_index),
    .out_row_index      (out_row_index),
    .out_x_offset       (out_x_offset),
    .out_y_offset       (out_y_offset),
    .out_rounded_height (out_rounded_height),
    .out_new_atlas      (out_new_atlas)
  );

  always #10 clk = ~clk;

  // Hard stop in case the block hangs or drops an item
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("shelf_rect_allocator_tb: errors");
      $finish;
    end
  end

  // Top of the next row in atlas a: just under its last row, or 0 when empty
  function automatic int next_shelf_top(int a);
    int last;
    if (shelf_count[a] == 0) begin
      return 0;
    end
    last = a * ROWS_MAX + shelf_count[a] - 1;
    return shelf_top_px[last] + shelf_height[last];
  endfunction

  // Place one rectangle on the predicted atlas pages and return the expected result
  function automatic placement_t place_rect(int w, int h_raw);
    placement_t p;
    int         h, a, r, s, fa, fr, slot, top;
    bit         found, have, fresh;
    p = '0;
    fa = 0;
    fr = 0;
    slot = 0;
    found = 1'b0;
    have = 1'b0;
    fresh = 1'b0;
    h = (h_raw + 3) & ~3;
    if (w > ATLAS_W || h > ATLAS_H) begin
      p.status = ST_OVERSIZE;
      return p;
    end
    // First fit: atlas order, then row order, exact height match with width left
    for (a = 0; a < atlas_open && !found; a++) begin
      for (r = 0; r < shelf_count[a] && !found; r++) begin
        s = a * ROWS_MAX + r;
        if (shelf_height[s] == h && ATLAS_W - shelf_fill[s] >= w) begin
          found = 1'b1;
          fa = a;
          fr = r;
          slot = s;
        end
      end
    end
    if (!found) begin
      // Open a row on the first atlas with a free slot and vertical room
      for (a = 0; a < atlas_open && !have; a++) begin
        top = next_shelf_top(a);
        if (shelf_count[a] < ROWS_MAX && top < ATLAS_H && top + h <= ATLAS_H) begin
          fa = a;
          have = 1'b1;
        end
      end
      if (!have) begin
        if (atlas_open >= ATLAS_MAX) begin
          p.status = ST_NO_SLOT;
          return p;
        end
        fa = atlas_open;
        atlas_open++;
        shelf_count[fa] = 0;
        fresh = 1'b1;
      end
      top = next_shelf_top(fa);
      fr = shelf_count[fa];
      slot = fa * ROWS_MAX + fr;
      shelf_height[slot] = h;
      shelf_fill[slot] = 0;
      shelf_top_px[slot] = top;
      shelf_count[fa] = fr + 1;
    end
    p.status = ST_PLACED;
    p.atlas = fa[ATLAS_IDX_W-1:0];
    p.row = fr[ROW_IDX_W-1:0];
    p.x = shelf_fill[slot][X_W-1:0];
    p.y = shelf_top_px[slot][Y_W-1:0];
    p.rh = h[RHEIGHT_W-1:0];
    p.fresh = fresh;
    shelf_fill[slot] = (shelf_fill[slot] + w) & 'hFFF;
    return p;
  endfunction

  // Send one request item; keep valid high across back-to-back items
  task automatic send_request(int w, int h);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_width <= w[REQ_WIDTH_W-1:0];
    in_req_height <= h[REQ_HEIGHT_W-1:0];
    do @(posedge clk); while (!in_ready);
    pending_placements.push_back(place_rect(w, h));
  endtask

  // Drop valid and hold until every expected result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
  endtask

  // Result side: check each accepted item, then draw the stall before the next one
  always @(posedge clk) begin
    placement_t want, got;
    if (rst_n && out_valid && out_ready) begin
      got.status = status_t'(out_status);
      got.atlas = out_atlas_index;
      got.row = out_row_index;
      got.x = out_x_offset;
      got.y = out_y_offset;
      got.rh = out_rounded_height;
      got.fresh = out_new_atlas;
      if (pending_placements.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected result item: status=%0d atlas=%0d row=%0d x=%0d y=%0d",
                   got.status, got.atlas, got.row, got.x, got.y);
        end
      end else begin
        want = pending_placements.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch: expected st=%0d at=%0d row=%0d x=%0d y=%0d h=%0d new=%0d",
                     want.status, want.atlas, want.row, want.x, want.y, want.rh,
                     want.fresh);
            $display("          actual   st=%0d at=%0d row=%0d x=%0d y=%0d h=%0d new=%0d",
                     got.status, got.atlas, got.row, got.x, got.y, got.rh, got.fresh);
          end
        end
      end
      out_stall = idle_on ? $urandom_range(0, 5) : 0;
    end else if (out_stall > 0) begin
      out_stall--;
    end
    out_ready <= rst_n && (out_stall == 0);
  end

  // Oversize requests: width past the page, rounded height past the page
  task automatic test_oversize();
    send_request(ATLAS_W + 1, 4);
    send_request(4095, 2047);
    send_request(100, ATLAS_H + 1);
    send_request(4095, 0);
  endtask

  // First rows on an empty allocator: zero sizes, exact full width, full height
  task automatic test_first_rows();
    send_request(0, 0);            // opens atlas 0, zero-height row
    send_request(ATLAS_W, 1);      // rounds to 4, new row at top 0
    send_request(0, 3);            // zero width still fits a full row
    send_request(1, 4);            // row full, stack a new row
    send_request(ATLAS_W, ATLAS_H - 3); // rounds to full height, opens atlas 1
    send_request(0, ATLAS_H);      // hit on the full-height row
    send_request(0, 0);            // hit on the zero-height row
    send_request(ATLAS_W, 0);      // fills the zero-height row exactly
    send_request(1, 0);            // new zero-height row
    send_request(ATLAS_W, ATLAS_H - 2); // no vertical room left anywhere, opens atlas 2
    send_request(ATLAS_W - 1, 2);
    send_request(1, 1);
  endtask

  // Fill one atlas with full-width zero-height rows until its row slots run out
  task automatic test_row_store_full();
    int i;
    for (i = 0; i < ROWS_MAX; i++) begin
      send_request(ATLAS_W, 0);
    end
  endtask

  // Mostly well-formed traffic that reuses and stacks rows, plus noise and edges
  task automatic test_random_traffic(int count);
    int i, pick, w, h, k, sub;
    for (i = 0; i < count; i++) begin
      // Leave stretches without any idling on either side
      idle_on = (i % 200) >= 40;
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        k = $urandom_range(0, 9);
        if (k == 0) begin
          w = 0;
        end else if (k == 1) begin
          w = $urandom_range(1000, ATLAS_W);
        end else begin
          w = $urandom_range(1, 160);
        end
        k = $urandom_range(0, 10) * 4;
        sub = $urandom_range(0, 3);
        h = (k > sub) ? k - sub : 0;
      end else if (pick < 90) begin
        w = $urandom_range(0, 4095);
        h = $urandom_range(0, 2047);
      end else begin
        w = $urandom_range(ATLAS_W - 2, ATLAS_W + 1);
        h = $urandom_range(ATLAS_H - 4, ATLAS_H + 4);
      end
      send_request(w, h);
    end
    idle_on = 1'b1;
  endtask

  // Use up every atlas page, then see requests refused for lack of a slot
  task automatic test_exhaust_atlases();
    int i;
    for (i = 0; i < 6; i++) begin
      send_request(ATLAS_W, ATLAS_H);
    end
    for (i = 0; i < 4; i++) begin
      send_request(ATLAS_W, 0);
    end
    send_request(1, 4);
    send_request(0, 0);
    send_request(ATLAS_W, 40);
  endtask

  initial begin
    foreach (shelf_count[a]) shelf_count[a] = 0;
    atlas_open = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_oversize();
    test_first_rows();
    // Pause the sender until the block has answered everything
    wait_drained();
    test_row_store_full();
    wait_drained();
    test_random_traffic(965);
    test_exhaust_atlases();
    wait_drained();

    // Catch any stray result after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_placements.size() == 0) begin
      $display("shelf_rect_allocator_tb: clean");
    end else begin
      $display("shelf_rect_allocator_tb: errors");
    end
    $finish;
  end

endmodule
